// ===== hdl/mfb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the max-flow block.
// No dependencies.
package mfb_pkg;

   localparam int CMD_WIDTH   = 2;
   localparam int NODE_WIDTH  = 6;
   localparam int VALUE_WIDTH = 16;
   localparam int COUNT_WIDTH = 7;
   localparam int FLOW_WIDTH  = 22;
   localparam logic [FLOW_WIDTH-1:0] OUT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] NODE_COUNT_RESET = 7'd2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_SET     = 2'd0,
      CMD_INC     = 2'd1,
      CMD_DEC     = 2'd2,
      CMD_COMPUTE = 2'd3
   } cmd_type;

endpackage

// ===== hdl/mfb_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the max-flow block: request, response, register write.
// Depends on mfb_pkg.
interface mfb_req_if;
   logic                                   valid;
   logic                                   ready;
   mfb_pkg::cmd_type                       command;
   logic [mfb_pkg::NODE_WIDTH-1:0]         from_node;
   logic [mfb_pkg::NODE_WIDTH-1:0]         to_node;
   logic [mfb_pkg::VALUE_WIDTH-1:0]        edge_capacity;
   modport source (output valid, command, from_node, to_node, edge_capacity, input ready);
   modport sink   (input valid, command, from_node, to_node, edge_capacity, output ready);
endinterface

interface mfb_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [mfb_pkg::FLOW_WIDTH-1:0]         max_flow;
   modport source (output valid, max_flow, input ready);
   modport sink   (input valid, max_flow, output ready);
endinterface

interface mfb_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [mfb_pkg::COUNT_WIDTH-1:0]        node_count;
   modport source (output valid, node_count, input ready);
   modport sink   (input valid, node_count, output ready);
endinterface

// ===== hdl/mfb_cap_edit.sv =====
`timescale 1ns / 1ps
// Capacity edit unit: new capacity from the old one and the command.
// Depends on mfb_pkg.
module mfb_cap_edit #(
   parameter int CAP_WIDTH = 16
) (
   input  mfb_pkg::cmd_type                  command,
   input  logic [CAP_WIDTH-1:0]              cap_old,
   input  logic [mfb_pkg::VALUE_WIDTH-1:0]   set_value,
   output logic [CAP_WIDTH-1:0]              cap_new
);

   logic [CAP_WIDTH-1:0] set_sat;

   // saturate a set value wider than the capacity field
   always_comb begin
      if (CAP_WIDTH < mfb_pkg::VALUE_WIDTH && (set_value >> CAP_WIDTH) != '0) begin
         set_sat = '1;
      end else begin
         set_sat = CAP_WIDTH'(set_value);
      end
   end

   always_comb begin
      unique case (command)
         mfb_pkg::CMD_SET: cap_new = set_sat;
         mfb_pkg::CMD_INC: cap_new = (cap_old == '1) ? cap_old : cap_old + 1'b1;
         mfb_pkg::CMD_DEC: cap_new = (cap_old == '0) ? cap_old : cap_old - 1'b1;
         default:          cap_new = cap_old;
      endcase
   end

endmodule

// ===== hdl/max_flow_bfs_augmenting_top.sv =====
`timescale 1ns / 1ps
// Max-flow block top level. Edge edits read the capacity memory, then write the result back.
// Compute: copy capacities into the residual memory; per search, seed, scan every active
// node per dequeued node, and per path edge read the parent and update both residuals. A
// search with no path ends it; its total waits until the output register's beat is accepted.
// Reset is synchronous; a pass over all NODES*NODES cells then zeroes cap_mem and holds off
// requests (register writes are taken throughout). Depends on mfb_pkg, mfb_if, mfb_cap_edit.
module max_flow_bfs_augmenting_top #(
   parameter int NODES     = 64,
   parameter int CAP_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   mfb_req_if.sink   req_ch,
   mfb_rsp_if.source rsp_ch,
   mfb_csr_if.sink   csr_ch
);

   localparam int IW = $clog2(NODES);          // node index
   localparam int NW = $clog2(NODES + 1);      // node count
   localparam int N2 = NODES * NODES;
   localparam int AW = $clog2(N2);             // matrix cell address
   localparam int RW = CAP_WIDTH + 1;          // residual, up to twice a capacity
   localparam int TW = CAP_WIDTH + IW;         // running total
   localparam int QW = IW + RW;                // queue entry: node and its bottleneck
   localparam int COUNT_W = mfb_pkg::COUNT_WIDTH;

   typedef enum logic [11:0] {
      ST_CLEAR = 12'b0000_0000_0001,
      ST_IDLE  = 12'b0000_0000_0010,
      ST_EDIT  = 12'b0000_0000_0100,
      ST_COPY  = 12'b0000_0000_1000,
      ST_INIT  = 12'b0000_0001_0000,
      ST_DEQ   = 12'b0000_0010_0000,
      ST_LOADU = 12'b0000_0100_0000,
      ST_SCAN  = 12'b0000_1000_0000,
      ST_APAR  = 12'b0001_0000_0000,
      ST_AP2   = 12'b0010_0000_0000,
      ST_AF1   = 12'b0100_0000_0000,
      ST_AF2   = 12'b1000_0000_0000
   } state_type;

   function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] u, input logic [IW-1:0] v);
      return AW'(AW'(u) * AW'(NODES)) + AW'(v);
   endfunction

   // memories
   logic [CAP_WIDTH-1:0] cap_mem   [N2];
   logic [RW-1:0]        res_mem   [N2];
   logic [IW-1:0]        par_mem   [NODES];
   logic [QW-1:0]        queue_mem [NODES];

   // control registers
   state_type                  state_ff, state_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [AW:0]                cp_ff, cp_in;
   logic                       cp_v_ff, cp_v_in;
   logic [AW-1:0]              cp_a_ff, cp_a_in;
   logic [COUNT_W-1:0]         node_count_ff, node_count_in;
   logic [NW-1:0]              n_ff, n_in;
   logic [NODES-1:0]           visited_ff, visited_in;
   logic [NW-1:0]              head_ff, head_in;
   logic [NW-1:0]              tail_ff, tail_in;
   logic [NW-1:0]              v_ff, v_in;
   logic                       chk_valid_ff, chk_valid_in;
   logic [IW-1:0]              chk_v_ff, chk_v_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]              total_ff, total_in;

   // payload registers
   logic [AW-1:0]                      ed_a_ff, ed_a_in;
   mfb_pkg::cmd_type                   ed_cmd_ff, ed_cmd_in;
   logic [mfb_pkg::VALUE_WIDTH-1:0]    ed_val_ff, ed_val_in;
   logic                               ed_ok_ff, ed_ok_in;
   logic [IW-1:0]                      u_ff, u_in;
   logic [RW-1:0]                      bu_ff, bu_in;
   logic [RW-1:0]                      amount_ff, amount_in;
   logic [IW-1:0]                      cur_ff, cur_in;
   logic [IW-1:0]                      prev_ff, prev_in;
   logic [mfb_pkg::FLOW_WIDTH-1:0]     out_ff, out_in;

   // memory read data
   logic [CAP_WIDTH-1:0] cap_q_ff;
   logic [RW-1:0]        res_q_ff;
   logic [IW-1:0]        par_q_ff;
   logic [QW-1:0]        q_q_ff;

   // memory port controls
   logic                 cap_we;
   logic [AW-1:0]        cap_wa, cap_ra;
   logic [CAP_WIDTH-1:0] cap_wd;
   logic                 res_we;
   logic [AW-1:0]        res_wa, res_ra;
   logic [RW-1:0]        res_wd;
   logic                 par_we;
   logic [IW-1:0]        par_wa, par_wd;
   logic                 q_we;
   logic [IW-1:0]        q_wa;
   logic [QW-1:0]        q_wd;

   logic                 req_fire, rsp_fire, from_ok;
   logic [NW-1:0]        n_act;
   logic [IW-1:0]        sink;
   logic [CAP_WIDTH-1:0] cap_new;
   logic [RW-1:0]        nb;
   logic                 hit, issue;

   mfb_cap_edit #(.CAP_WIDTH(CAP_WIDTH)) u_edit (
      .command   (ed_cmd_ff),
      .cap_old   (cap_q_ff),
      .set_value (ed_val_ff),
      .cap_new   (cap_new)
   );

   // handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.max_flow = out_ff;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // clamp the node count into the supported range
   always_comb begin
      if (node_count_ff < COUNT_W'(2)) begin
         n_act = NW'(2);
      end else if (32'(node_count_ff) > NODES) begin
         n_act = NW'(NODES);
      end else begin
         n_act = NW'(node_count_ff);
      end
   end

   assign from_ok = (32'(req_ch.from_node) < NODES) && (32'(req_ch.to_node) < NODES);
   assign sink    = IW'(n_ff - 1'b1);
   assign issue   = (v_ff < n_ff);
   assign hit     = chk_valid_ff && !visited_ff[chk_v_ff] && (res_q_ff != '0);
   assign nb      = (bu_ff < res_q_ff) ? bu_ff : res_q_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cp_in         = cp_ff;
      cp_v_in       = 1'b0;
      cp_a_in       = cp_a_ff;
      n_in          = n_ff;
      visited_in    = visited_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      v_in          = v_ff;
      chk_valid_in  = 1'b0;
      chk_v_in      = chk_v_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      total_in      = total_ff;
      ed_a_in       = ed_a_ff;
      ed_cmd_in     = ed_cmd_ff;
      ed_val_in     = ed_val_ff;
      ed_ok_in      = ed_ok_ff;
      u_in          = u_ff;
      bu_in         = bu_ff;
      amount_in     = amount_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      out_in        = out_ff;
      node_count_in = csr_ch.valid ? csr_ch.node_count : node_count_ff;

      cap_we = 1'b0;
      cap_wa = clr_ff;
      cap_wd = '0;
      cap_ra = cell_addr(IW'(req_ch.from_node), IW'(req_ch.to_node));
      res_we = 1'b0;
      res_wa = cp_a_ff;
      res_wd = RW'(cap_q_ff);
      res_ra = cell_addr(u_ff, IW'(v_ff));
      par_we = 1'b0;
      par_wa = chk_v_ff;
      par_wd = u_ff;
      q_we   = 1'b0;
      q_wa   = tail_ff[IW-1:0];
      q_wd   = {chk_v_ff, nb};

      unique case (state_ff)
         ST_CLEAR: begin
            // zero the capacity memory after reset
            cap_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(N2 - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.command == mfb_pkg::CMD_COMPUTE) begin
                  n_in     = n_act;
                  total_in = '0;
                  cp_in    = '0;
                  state_in = ST_COPY;
               end else begin
                  ed_a_in   = cap_ra;
                  ed_cmd_in = req_ch.command;
                  ed_val_in = req_ch.edge_capacity;
                  ed_ok_in  = from_ok;
                  state_in  = ST_EDIT;
               end
            end
         end
         ST_EDIT: begin
            // write back the edited capacity; out-of-range edges are dropped
            cap_we   = ed_ok_ff;
            cap_wa   = ed_a_ff;
            cap_wd   = cap_new;
            state_in = ST_IDLE;
         end
         ST_COPY: begin
            // residual starts as capacity (all flows clear)
            cap_ra = cp_ff[AW-1:0];
            res_we = cp_v_ff;
            if (cp_ff < (AW+1)'(N2)) begin
               cp_v_in = 1'b1;
               cp_a_in = cp_ff[AW-1:0];
               cp_in   = cp_ff + 1'b1;
            end else if (cp_v_ff) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            // seed a search from the source with an unbounded bottleneck
            visited_in    = '0;
            visited_in[0] = 1'b1;
            q_we          = 1'b1;
            q_wa          = '0;
            q_wd          = {IW'(0), {RW{1'b1}}};
            head_in       = '0;
            tail_in       = NW'(1);
            state_in      = ST_DEQ;
         end
         ST_DEQ: begin
            if (head_ff == tail_ff) begin
               // no path left: deliver the total, saturated, once the output register frees up
               if (!rsp_valid_ff || rsp_fire) begin
                  rsp_valid_in = 1'b1;
                  out_in   = (64'(total_ff) > 64'(mfb_pkg::OUT_MAX)) ? mfb_pkg::OUT_MAX
                                                                      : mfb_pkg::FLOW_WIDTH'(total_ff);
                  state_in = ST_IDLE;
               end
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = ST_LOADU;
            end
         end
         ST_LOADU: begin
            u_in     = q_q_ff[QW-1:RW];
            bu_in    = q_q_ff[RW-1:0];
            v_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // issue one neighbor read a cycle, check the previous one
            if (issue) begin
               v_in         = v_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_v_in     = IW'(v_ff);
            end else if (!chk_valid_ff) begin
               state_in = ST_DEQ;
            end
            if (hit) begin
               visited_in[chk_v_ff] = 1'b1;
               par_we = 1'b1;
               if (chk_v_ff == sink) begin
                  amount_in    = nb;
                  total_in     = total_ff + TW'(nb);
                  cur_in       = sink;
                  chk_valid_in = 1'b0;
                  state_in     = ST_APAR;
               end else if (32'(tail_ff) < NODES) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end
         end
         ST_APAR: begin
            state_in = ST_AP2;
         end
         ST_AP2: begin
            prev_in  = par_q_ff;
            res_ra   = cell_addr(par_q_ff, cur_ff);
            state_in = ST_AF1;
         end
         ST_AF1: begin
            res_we   = 1'b1;
            res_wa   = cell_addr(prev_ff, cur_ff);
            res_wd   = res_q_ff - amount_ff;
            res_ra   = cell_addr(cur_ff, prev_ff);
            state_in = ST_AF2;
         end
         ST_AF2: begin
            res_we = 1'b1;
            res_wa = cell_addr(cur_ff, prev_ff);
            res_wd = res_q_ff + amount_ff;
            cur_in = prev_ff;
            state_in = (prev_ff == '0) ? ST_INIT : ST_APAR;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cap_we) cap_mem[cap_wa] <= cap_wd;
      cap_q_ff <= cap_mem[cap_ra];
   end

   always_ff @(posedge clock) begin
      if (res_we) res_mem[res_wa] <= res_wd;
      res_q_ff <= res_mem[res_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_wa] <= par_wd;
      par_q_ff <= par_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_wa] <= q_wd;
      q_q_ff <= queue_mem[head_ff[IW-1:0]];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         cp_ff         <= '0;
         cp_v_ff       <= 1'b0;
         node_count_ff <= mfb_pkg::NODE_COUNT_RESET;
         n_ff          <= NW'(2);
         visited_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         v_ff          <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cp_ff         <= cp_in;
         cp_v_ff       <= cp_v_in;
         node_count_ff <= node_count_in;
         n_ff          <= n_in;
         visited_ff    <= visited_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         v_ff          <= v_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         total_ff      <= total_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cp_a_ff   <= cp_a_in;
      chk_v_ff  <= chk_v_in;
      ed_a_ff   <= ed_a_in;
      ed_cmd_ff <= ed_cmd_in;
      ed_val_ff <= ed_val_in;
      ed_ok_ff  <= ed_ok_in;
      u_ff      <= u_in;
      bu_ff     <= bu_in;
      amount_ff <= amount_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      out_ff    <= out_in;
   end

   // checks
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed tail");

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> state_ff == ST_SCAN) else $error("neighbor check outside scan");

   a_rsp_from_deq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DEQ) else $error("result without search end");

   a_amount_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APAR |-> amount_ff != '0) else $error("augment by zero");

endmodule
